>>> hw/rtl/skf_pkg.sv
package skf_pkg;

    localparam int unsigned FRAC_BITS = 16;
    localparam logic [31:0] ONE_Q     = 32'd1 << FRAC_BITS;

    localparam int unsigned SERIAL_STEPS = 33;
    localparam int unsigned CNT_W        = $clog2(SERIAL_STEPS);

    localparam logic [1:0] CFG_MEAS_VAR   = 2'd0;
    localparam logic [1:0] CFG_MOTION_VAR = 2'd1;
    localparam logic [1:0] CFG_INIT_MEAN  = 2'd2;
    localparam logic [1:0] CFG_INIT_VAR   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIOR,
        ST_ABS,
        ST_MUL,
        ST_DIV,
        ST_ROUND,
        ST_FUSE,
        ST_PRED
    } skf_state_t;

endpackage

>>> hw/rtl/scalar_kalman_filter_core.sv
// Channel   Direction  tdata (lowest bit up)                           tuser
// s_axis    in         measured_value[31:0], motion_step[63:32]        restart
// m_axis    out        estimate_mean[31:0], estimate_variance[63:32]   saturated
// cfg       in         cfg_addr selects register, cfg_wdata[31:0]      -
//
// Each item runs through two 33-step bit-serial loops (shift-add multiply,
// then restoring divide) plus six further steps (accept, prior, magnitude,
// round, fuse, predict), one item at a time.
// s_axis_tready is high only between items; the result register frees the
// core while a result waits, and a held result stalls the last step only.
// rst_n clears the control state and loads the register defaults at once.
module scalar_kalman_filter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // measured_value, motion_step
    input  logic        s_axis_tuser,   // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // estimate_mean, estimate_variance
    output logic        m_axis_tuser,   // saturated
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import skf_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SERIAL_STEPS - 1);

    skf_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic        m_tvalid_reg;
    logic        loaded_reg;
    logic [31:0] held_mean_reg, held_var_reg;
    logic [31:0] meas_var_reg, motion_var_reg, init_mean_reg, init_var_reg;

    logic [31:0] z_reg, motion_reg, mu_reg, p_reg, r_reg, fused_reg;
    logic        restart_reg, neg_reg;
    logic [32:0] s_reg, d_reg;
    logic [32:0] mh_reg, ml_reg, vh_reg, vl_reg;
    logic [31:0] out_mean_reg, out_var_reg;
    logic        out_sat_reg;

    logic        in_fire, out_free, pred_fire;
    logic [31:0] prior_mu, prior_p, r_eff;
    logic [33:0] m_sum, v_sum, m_rem2, v_rem2;
    logic [34:0] m_diff, v_diff;
    logic        m_ge, v_ge, m_up, v_up;
    logic [33:0] fused_full;
    logic [32:0] mean_full, var_full;
    logic [31:0] mean_sat, var_sat;
    logic        mean_ovf, var_ovf;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_tvalid_reg || m_axis_tready;
    assign pred_fire = (state_reg == ST_PRED) && out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {out_var_reg, out_mean_reg};
    assign m_axis_tuser  = out_sat_reg;

    assign prior_mu = (restart_reg || !loaded_reg) ? init_mean_reg : held_mean_reg;
    assign prior_p  = (restart_reg || !loaded_reg) ? init_var_reg : held_var_reg;
    assign r_eff    = (meas_var_reg == 32'd0) ? 32'd1 : meas_var_reg;

    assign m_sum = {1'b0, mh_reg} + (ml_reg[0] ? {2'b00, p_reg} : 34'd0);
    assign v_sum = {1'b0, vh_reg} + (vl_reg[0] ? {2'b00, p_reg} : 34'd0);

    assign m_rem2 = {mh_reg, ml_reg[32]};
    assign v_rem2 = {vh_reg, vl_reg[32]};
    assign m_diff = {1'b0, m_rem2} - {2'b00, s_reg};
    assign v_diff = {1'b0, v_rem2} - {2'b00, s_reg};
    assign m_ge   = !m_diff[34];
    assign v_ge   = !v_diff[34];

    assign m_up = ({mh_reg, 1'b0} >= {1'b0, s_reg});
    assign v_up = ({vh_reg, 1'b0} >= {1'b0, s_reg});

    assign fused_full = neg_reg ? ({{2{mu_reg[31]}}, mu_reg} - {1'b0, ml_reg})
                                : ({{2{mu_reg[31]}}, mu_reg} + {1'b0, ml_reg});

    assign mean_full = {fused_reg[31], fused_reg} + {motion_reg[31], motion_reg};
    assign mean_ovf  = (mean_full[32] != mean_full[31]);
    assign mean_sat  = mean_ovf ? (mean_full[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                : mean_full[31:0];
    assign var_full  = {1'b0, vl_reg[31:0]} + {1'b0, motion_var_reg};
    assign var_ovf   = var_full[32];
    assign var_sat   = var_ovf ? 32'hFFFF_FFFF : var_full[31:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_PRIOR;
                end
            end
            ST_PRIOR: state_next = ST_ABS;
            ST_ABS:   state_next = ST_MUL;
            ST_MUL:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: state_next = ST_FUSE;
            ST_FUSE:  state_next = ST_PRED;
            ST_PRED:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            loaded_reg     <= 1'b0;
            held_mean_reg  <= 32'd0;
            held_var_reg   <= 32'd0;
            meas_var_reg   <= ONE_Q;
            motion_var_reg <= ONE_Q;
            init_mean_reg  <= 32'd0;
            init_var_reg   <= ONE_Q;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_MEAS_VAR:   meas_var_reg   <= cfg_wdata;
                    CFG_MOTION_VAR: motion_var_reg <= cfg_wdata;
                    CFG_INIT_MEAN:  init_mean_reg  <= cfg_wdata;
                    CFG_INIT_VAR:   init_var_reg   <= cfg_wdata;
                    default:        meas_var_reg   <= meas_var_reg;
                endcase
            end

            if ((state_reg == ST_MUL) || (state_reg == ST_DIV))
            begin
                cnt_reg <= (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end

            if (pred_fire)
            begin
                m_tvalid_reg  <= 1'b1;
                held_mean_reg <= mean_sat;
                held_var_reg  <= var_sat;
                loaded_reg    <= 1'b1;
            end
            else if (m_tvalid_reg && m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            z_reg       <= s_axis_tdata[31:0];
            motion_reg  <= s_axis_tdata[63:32];
            restart_reg <= s_axis_tuser;
        end

        unique case (state_reg)
            ST_PRIOR:
            begin
                mu_reg <= prior_mu;
                p_reg  <= prior_p;
                r_reg  <= r_eff;
                s_reg  <= {1'b0, prior_p} + {1'b0, r_eff};
                d_reg  <= {z_reg[31], z_reg} - {prior_mu[31], prior_mu};
            end
            ST_ABS:
            begin
                neg_reg <= d_reg[32];
                mh_reg  <= 33'd0;
                ml_reg  <= d_reg[32] ? (33'd0 - d_reg) : d_reg;
                vh_reg  <= 33'd0;
                vl_reg  <= {1'b0, r_reg};
            end
            ST_MUL:
            begin
                mh_reg <= m_sum[33:1];
                ml_reg <= {m_sum[0], ml_reg[32:1]};
                vh_reg <= v_sum[33:1];
                vl_reg <= {v_sum[0], vl_reg[32:1]};
            end
            ST_DIV:
            begin
                mh_reg <= m_ge ? m_diff[32:0] : m_rem2[32:0];
                ml_reg <= {ml_reg[31:0], m_ge};
                vh_reg <= v_ge ? v_diff[32:0] : v_rem2[32:0];
                vl_reg <= {vl_reg[31:0], v_ge};
            end
            ST_ROUND:
            begin
                ml_reg <= ml_reg + {32'd0, m_up};
                vl_reg <= vl_reg + {32'd0, v_up};
            end
            ST_FUSE:
            begin
                fused_reg <= fused_full[31:0];
            end
            ST_PRED:
            begin
                if (out_free)
                begin
                    out_mean_reg <= mean_sat;
                    out_var_reg  <= var_sat;
                    out_sat_reg  <= mean_ovf || var_ovf;
                end
            end
            default:
            begin
                fused_reg <= fused_reg;
            end
        endcase
    end

endmodule
